>>> src/spe_pkg.sv
// Shared types and constants for the swap permutation enumerator.
// Used by spe_swap_unit, the top level and the checker; no dependencies.
package spe_pkg;

    localparam int POS_W      = 3;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_W      = 4;
    localparam int S_FIELDS_W = POS_W + DATA_W;
    localparam int S_TDATA_W  = 40;
    localparam int M_FIELDS_W = POS_W + DATA_W + CNT_W;
    localparam int M_TDATA_W  = 72;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic STAT_ELEMENT   = 1'b0;
    localparam logic STAT_EXHAUSTED = 1'b1;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_SWAP
    } unit_op_t;

    typedef struct packed {
        logic     valid;
        unit_op_t op;
    } unit_ctl_t;

    typedef enum logic [1:0] {
        US_IDLE,
        US_RD_B,
        US_WR_A,
        US_WR_B
    } unit_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RST_STEP,
        ST_RST_WAIT,
        ST_LOAD_WR,
        ST_ADV_UNDO,
        ST_ADV_UWAIT,
        ST_ADV_CHECK,
        ST_ADV_RWAIT,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMIT_EXH
    } seq_state_t;

endpackage

>>> src/spe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

>>> src/spe_swap_unit.sv
// Shared element unit: read, write and two-slot swap on the element RAM.
// Depends on spe_pkg and spe_ram.
module spe_swap_unit #(
    parameter int MAX_ELEMENTS = 8,
    parameter int ELEM_WIDTH   = 32,
    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  spe_pkg::unit_ctl_t     ctl,
    input  logic [AW-1:0]          addr_a,
    input  logic [AW-1:0]          addr_b,
    input  logic [ELEM_WIDTH-1:0]  wdata,
    output logic                   ready,
    output logic [ELEM_WIDTH-1:0]  rdata
);

    spe_pkg::unit_state_t state_reg, state_next;
    logic [AW-1:0]         a_reg, a_next;
    logic [AW-1:0]         b_reg, b_next;
    logic [ELEM_WIDTH-1:0] tmp_reg, tmp_next;

    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [ELEM_WIDTH-1:0] ram_wr_data;
    logic [AW-1:0]         ram_rd_addr;
    logic [ELEM_WIDTH-1:0] ram_rd_data;

    spe_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_ELEMENTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spe_pkg::US_IDLE:
            begin
                if (ctl.valid && ctl.op == spe_pkg::OP_SWAP && addr_a != addr_b)
                begin
                    state_next = spe_pkg::US_RD_B;
                end
            end
            spe_pkg::US_RD_B: state_next = spe_pkg::US_WR_A;
            spe_pkg::US_WR_A: state_next = spe_pkg::US_WR_B;
            spe_pkg::US_WR_B: state_next = spe_pkg::US_IDLE;
            default:          state_next = spe_pkg::US_IDLE;
        endcase
    end

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        tmp_next    = tmp_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_a;
        ram_wr_data = wdata;
        ram_rd_addr = addr_a;
        unique case (state_reg)
            spe_pkg::US_IDLE:
            begin
                a_next = addr_a;
                b_next = addr_b;
                if (ctl.valid && ctl.op == spe_pkg::OP_WRITE)
                begin
                    ram_wr_en = 1'b1;
                end
            end
            spe_pkg::US_RD_B:
            begin
                ram_rd_addr = b_reg;
                tmp_next    = ram_rd_data;
            end
            spe_pkg::US_WR_A:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = a_reg;
                ram_wr_data = ram_rd_data;
            end
            spe_pkg::US_WR_B:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = b_reg;
                ram_wr_data = tmp_reg;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spe_pkg::US_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        tmp_reg <= tmp_next;
    end

    assign ready = (state_reg == spe_pkg::US_IDLE);
    assign rdata = ram_rd_data;

endmodule

>>> src/swap_permutation_enumerator_top.sv
// Top level of the swap permutation enumerator: request sequencer, level stack,
// output register. Depends on spe_pkg and spe_swap_unit.
//
// Load requests write one element and restart; next requests emit the following
// permutation in depth-first swap-and-restore order, n elements with the last one
// marked, or a single exhausted result. All element moves go through one shared
// swap unit on the element RAM: a swap of two distinct slots reads both slots, then
// writes slot a and slot b; a swap of a slot with itself leaves the unit idle. A
// load first swaps back the levels still swapped (at most n). A next request
// swaps on the path back up the level stack and at the level that advances (at
// most n+1 swaps), then emits its elements as the output side takes them. The
// input is not ready for the whole of a request. A write of element_count
// restarts in the same way as a load.
module swap_permutation_enumerator_top #(
    parameter int MAX_ELEMENTS = 8,
    parameter int ELEM_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [spe_pkg::S_TDATA_W-1:0] s_axis_tdata,   // position, value, pad
    input  logic                          s_axis_tuser,   // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [spe_pkg::M_TDATA_W-1:0] m_axis_tdata,   // position_res, value_res,
                                                          // perm_count, pad
    output logic                          m_axis_tuser,   // status
    output logic                          m_axis_tlast,
    input  logic                          cfg_wr_en,
    input  logic [spe_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SW = $clog2(MAX_ELEMENTS + 1);

    spe_pkg::seq_state_t state_reg, state_next;

    logic [spe_pkg::CFG_W-1:0]  ec_reg, ec_next;
    logic                       rst_pend_reg, rst_pend_next;
    logic                       load_pend_reg, load_pend_next;
    logic [spe_pkg::POS_W-1:0]  ld_pos_reg, ld_pos_next;
    logic [spe_pkg::DATA_W-1:0] ld_val_reg, ld_val_next;
    logic [SW-1:0]              stack_reg [MAX_ELEMENTS];
    logic [SW-1:0]              stack_next [MAX_ELEMENTS];
    logic [SW-1:0]              depth_reg, depth_next;
    logic                       started_reg, started_next;
    logic                       exh_reg, exh_next;
    logic [spe_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]              lv_reg, lv_next;
    logic [SW-1:0]              k_reg, k_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_status_reg, m_status_next;
    logic                       m_last_reg, m_last_next;
    logic [spe_pkg::POS_W-1:0]  m_pos_reg, m_pos_next;
    logic [spe_pkg::DATA_W-1:0] m_val_reg, m_val_next;
    logic [spe_pkg::CNT_W-1:0]  m_cnt_reg, m_cnt_next;

    spe_pkg::unit_ctl_t         u_ctl;
    logic [AW-1:0]              u_addr_a;
    logic [AW-1:0]              u_addr_b;
    logic [ELEM_WIDTH-1:0]      u_wdata;
    logic                       u_ready;
    logic [ELEM_WIDTH-1:0]      u_rdata;

    logic                       in_fire;
    logic                       out_free;
    logic                       restart_live;
    logic [SW-1:0]              lv_m1;
    logic [SW-1:0]              stack_lv;
    logic [SW-1:0]              stack_lv_m1;
    logic [SW-1:0]              stack_inc;
    logic [SW-1:0]              n_used;
    logic                       pos_ok;
    logic [spe_pkg::CNT_W-1:0]  cnt_inc;

    spe_swap_unit #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ELEM_WIDTH   (ELEM_WIDTH)
    ) u_swap_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (u_ctl),
        .addr_a (u_addr_a),
        .addr_b (u_addr_b),
        .wdata  (u_wdata),
        .ready  (u_ready),
        .rdata  (u_rdata)
    );

    assign s_axis_tready = (state_reg == spe_pkg::ST_IDLE) && !rst_pend_reg && !cfg_wr_en;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign restart_live  = started_reg && !exh_reg && (lv_reg != '0);
    assign lv_m1         = lv_reg - SW'(1);
    assign stack_lv      = stack_reg[lv_reg[AW-1:0]];
    assign stack_lv_m1   = stack_reg[lv_m1[AW-1:0]];
    assign stack_inc     = stack_lv + SW'(1);
    assign pos_ok        = (32'(ld_pos_reg) < MAX_ELEMENTS);
    assign cnt_inc       = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    always_comb
    begin
        if (ec_reg == '0)
        begin
            n_used = SW'(1);
        end
        else if ({1'b0, ec_reg} > 5'(MAX_ELEMENTS))
        begin
            n_used = SW'(MAX_ELEMENTS);
        end
        else
        begin
            n_used = SW'(ec_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spe_pkg::ST_IDLE:
            begin
                if (rst_pend_reg)
                begin
                    state_next = spe_pkg::ST_RST_STEP;
                end
                else if (in_fire)
                begin
                    if (s_axis_tuser == spe_pkg::ACT_LOAD)
                    begin
                        state_next = spe_pkg::ST_RST_STEP;
                    end
                    else if (exh_reg)
                    begin
                        state_next = spe_pkg::ST_EMIT_EXH;
                    end
                    else if (!started_reg)
                    begin
                        state_next = spe_pkg::ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = spe_pkg::ST_ADV_UNDO;
                    end
                end
            end
            spe_pkg::ST_RST_STEP:
            begin
                if (restart_live)
                begin
                    state_next = spe_pkg::ST_RST_WAIT;
                end
                else if (load_pend_reg)
                begin
                    state_next = spe_pkg::ST_LOAD_WR;
                end
                else
                begin
                    state_next = spe_pkg::ST_IDLE;
                end
            end
            spe_pkg::ST_RST_WAIT:
            begin
                if (u_ready)
                begin
                    state_next = spe_pkg::ST_RST_STEP;
                end
            end
            spe_pkg::ST_LOAD_WR:  state_next = spe_pkg::ST_IDLE;
            spe_pkg::ST_ADV_UNDO: state_next = spe_pkg::ST_ADV_UWAIT;
            spe_pkg::ST_ADV_UWAIT:
            begin
                if (u_ready)
                begin
                    state_next = spe_pkg::ST_ADV_CHECK;
                end
            end
            spe_pkg::ST_ADV_CHECK:
            begin
                if (stack_inc < depth_reg)
                begin
                    state_next = spe_pkg::ST_ADV_RWAIT;
                end
                else if (lv_reg == '0)
                begin
                    state_next = spe_pkg::ST_EMIT_EXH;
                end
                else
                begin
                    state_next = spe_pkg::ST_ADV_UNDO;
                end
            end
            spe_pkg::ST_ADV_RWAIT:
            begin
                if (u_ready)
                begin
                    state_next = spe_pkg::ST_EMIT_RD;
                end
            end
            spe_pkg::ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = spe_pkg::ST_EMIT_CAP;
                end
            end
            spe_pkg::ST_EMIT_CAP:
            begin
                if (k_reg + SW'(1) == depth_reg)
                begin
                    state_next = spe_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = spe_pkg::ST_EMIT_RD;
                end
            end
            spe_pkg::ST_EMIT_EXH:
            begin
                if (out_free)
                begin
                    state_next = spe_pkg::ST_IDLE;
                end
            end
            default: state_next = spe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ec_next        = cfg_wr_en ? cfg_wr_data : ec_reg;
        rst_pend_next  = rst_pend_reg;
        load_pend_next = load_pend_reg;
        ld_pos_next    = ld_pos_reg;
        ld_val_next    = ld_val_reg;
        stack_next     = stack_reg;
        depth_next     = depth_reg;
        started_next   = started_reg;
        exh_next       = exh_reg;
        cnt_next       = cnt_reg;
        lv_next        = lv_reg;
        k_next         = k_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_status_next  = m_status_reg;
        m_last_next    = m_last_reg;
        m_pos_next     = m_pos_reg;
        m_val_next     = m_val_reg;
        m_cnt_next     = m_cnt_reg;
        u_ctl.valid    = 1'b0;
        u_ctl.op       = spe_pkg::OP_READ;
        u_addr_a       = lv_reg[AW-1:0];
        u_addr_b       = stack_lv[AW-1:0];
        u_wdata        = ELEM_WIDTH'(ld_val_reg);

        unique case (state_reg)
            spe_pkg::ST_IDLE:
            begin
                if (rst_pend_reg)
                begin
                    load_pend_next = 1'b0;
                    lv_next        = depth_reg;
                end
                else if (in_fire)
                begin
                    if (s_axis_tuser == spe_pkg::ACT_LOAD)
                    begin
                        load_pend_next = 1'b1;
                        ld_pos_next    = s_axis_tdata[spe_pkg::POS_W-1:0];
                        ld_val_next    = s_axis_tdata[spe_pkg::S_FIELDS_W-1:spe_pkg::POS_W];
                        lv_next        = depth_reg;
                    end
                    else if (!exh_reg && !started_reg)
                    begin
                        for (int j = 0; j < MAX_ELEMENTS; j++)
                        begin
                            stack_next[j] = SW'(j);
                        end
                        depth_next   = n_used;
                        started_next = 1'b1;
                        cnt_next     = cnt_inc;
                        k_next       = '0;
                    end
                    else if (!exh_reg)
                    begin
                        lv_next = depth_reg - SW'(1);
                    end
                end
                rst_pend_next = cfg_wr_en;
            end
            spe_pkg::ST_RST_STEP:
            begin
                if (restart_live)
                begin
                    u_ctl.valid = 1'b1;
                    u_ctl.op    = spe_pkg::OP_SWAP;
                    u_addr_a    = lv_m1[AW-1:0];
                    u_addr_b    = stack_lv_m1[AW-1:0];
                    lv_next     = lv_m1;
                end
                else
                begin
                    started_next = 1'b0;
                    exh_next     = 1'b0;
                    cnt_next     = '0;
                end
            end
            spe_pkg::ST_LOAD_WR:
            begin
                u_ctl.valid = pos_ok;
                u_ctl.op    = spe_pkg::OP_WRITE;
                u_addr_a    = AW'(ld_pos_reg);
            end
            spe_pkg::ST_ADV_UNDO:
            begin
                u_ctl.valid = 1'b1;
                u_ctl.op    = spe_pkg::OP_SWAP;
            end
            spe_pkg::ST_ADV_CHECK:
            begin
                stack_next[lv_reg[AW-1:0]] = stack_inc;
                if (stack_inc < depth_reg)
                begin
                    u_ctl.valid = 1'b1;
                    u_ctl.op    = spe_pkg::OP_SWAP;
                    u_addr_b    = stack_inc[AW-1:0];
                end
                else if (lv_reg == '0)
                begin
                    exh_next = 1'b1;
                end
                else
                begin
                    lv_next = lv_m1;
                end
            end
            spe_pkg::ST_ADV_RWAIT:
            begin
                if (u_ready)
                begin
                    for (int j = 0; j < MAX_ELEMENTS; j++)
                    begin
                        if (SW'(j) > lv_reg)
                        begin
                            stack_next[j] = SW'(j);
                        end
                    end
                    cnt_next = cnt_inc;
                    k_next   = '0;
                end
            end
            spe_pkg::ST_EMIT_RD:
            begin
                u_ctl.valid = out_free;
                u_ctl.op    = spe_pkg::OP_READ;
                u_addr_a    = k_reg[AW-1:0];
            end
            spe_pkg::ST_EMIT_CAP:
            begin
                m_valid_next  = 1'b1;
                m_status_next = spe_pkg::STAT_ELEMENT;
                m_last_next   = (k_reg + SW'(1) == depth_reg);
                m_pos_next    = spe_pkg::POS_W'(k_reg);
                m_val_next    = spe_pkg::DATA_W'(u_rdata);
                m_cnt_next    = cnt_reg;
                k_next        = k_reg + SW'(1);
            end
            spe_pkg::ST_EMIT_EXH:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = spe_pkg::STAT_EXHAUSTED;
                    m_last_next   = 1'b1;
                    m_pos_next    = '0;
                    m_val_next    = '0;
                    m_cnt_next    = cnt_reg;
                end
            end
            default:
            begin
                u_ctl.valid = 1'b0;
            end
        endcase

        if (cfg_wr_en)
        begin
            rst_pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spe_pkg::ST_IDLE;
            ec_reg        <= spe_pkg::CFG_W'(1);
            rst_pend_reg  <= 1'b0;
            load_pend_reg <= 1'b0;
            for (int j = 0; j < MAX_ELEMENTS; j++)
            begin
                stack_reg[j] <= '0;
            end
            depth_reg     <= '0;
            started_reg   <= 1'b0;
            exh_reg       <= 1'b0;
            cnt_reg       <= '0;
            lv_reg        <= '0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ec_reg        <= ec_next;
            rst_pend_reg  <= rst_pend_next;
            load_pend_reg <= load_pend_next;
            stack_reg     <= stack_next;
            depth_reg     <= depth_next;
            started_reg   <= started_next;
            exh_reg       <= exh_next;
            cnt_reg       <= cnt_next;
            lv_reg        <= lv_next;
            k_reg         <= k_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_pos_reg   <= ld_pos_next;
        ld_val_reg   <= ld_val_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        m_pos_reg    <= m_pos_next;
        m_val_reg    <= m_val_next;
        m_cnt_reg    <= m_cnt_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {(spe_pkg::M_TDATA_W - spe_pkg::M_FIELDS_W)'(0),
                            m_cnt_reg, m_val_reg, m_pos_reg};

endmodule

>>> src/spe_checker.sv
// Port-level checks for the swap permutation enumerator, bound to the top level.
// Depends on spe_pkg and swap_permutation_enumerator_top.
module spe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [spe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [spe_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast,
    input logic                          cfg_wr_en,
    input logic [spe_pkg::CFG_W-1:0]     cfg_wr_data
);

    logic unused_in;
    assign unused_in = s_axis_tvalid ^ (^s_axis_tdata) ^ s_axis_tuser ^ (^cfg_wr_data);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == spe_pkg::STAT_EXHAUSTED) |->
            (m_axis_tlast && m_axis_tdata[spe_pkg::POS_W+spe_pkg::DATA_W-1:0] == '0))
        else $error("exhausted result not marked or carries element data");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
            (!m_axis_tvalid ||
             m_axis_tdata[spe_pkg::POS_W-1:0] ==
                 spe_pkg::POS_W'($past(m_axis_tdata[spe_pkg::POS_W-1:0]) + 1'b1)))
        else $error("element positions out of order");

    a_busy_no_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> !s_axis_tready)
        else $error("input ready during a register write");

endmodule

bind swap_permutation_enumerator_top spe_checker u_spe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
);

>>> bench/swap_permutation_enumerator_top_tb.sv
// Self-checking bench for swap_permutation_enumerator_top: directed table, then random phases.
// Keeps its own model of the swap-and-restore enumeration and compares every result.
// Depends on spe_pkg and the enumerator RTL.
module swap_permutation_enumerator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spe_pkg::*;

    localparam int NUM_SLOTS     = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 210;
    localparam int QUIET_FROM    = 180;

    typedef struct packed {
        logic              status;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic              last;
        logic [CNT_W-1:0]  cnt;
    } perm_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic              act;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic              typed;
        perm_result_t      res;
    } stim_row_t;

    localparam perm_result_t NO_RES = '0;
    localparam int NUM_ROWS = 31;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ROW_ITEM, ACT_LOAD,    3'd0, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd1, 32'h0000_0000, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd2, 32'h8000_0000, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd3, 32'h0000_0001, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd4, 32'h5555_5555, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd5, 32'hAAAA_AAAA, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd6, 32'h1234_5678, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd7, 32'h7FFF_FFFF, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b1,
          '{STAT_ELEMENT, 3'd0, 32'hFFFF_FFFF, 1'b1, 32'd1}},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b1,
          '{STAT_EXHAUSTED, 3'd0, 32'h0, 1'b1, 32'd1}},
        '{ROW_ITEM, ACT_REQUEST, 3'd7, 32'hFFFF_FFFF, 1'b1,
          '{STAT_EXHAUSTED, 3'd0, 32'h0, 1'b1, 32'd1}},
        '{ROW_ITEM, ACT_LOAD,    3'd0, 32'hCAFE_F00D, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b1,
          '{STAT_ELEMENT, 3'd0, 32'hCAFE_F00D, 1'b1, 32'd1}},
        '{ROW_CFG,  ACT_LOAD,    3'd0, 32'd3, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd2, 32'h0F0F_0F0F, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_LOAD,    3'd1, 32'hF0F0_F0F0, 1'b0, NO_RES},
        '{ROW_CFG,  ACT_LOAD,    3'd0, 32'd0, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b1,
          '{STAT_ELEMENT, 3'd0, 32'hCAFE_F00D, 1'b1, 32'd1}},
        '{ROW_CFG,  ACT_LOAD,    3'd0, 32'd8, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES},
        '{ROW_CFG,  ACT_LOAD,    3'd0, 32'd15, 1'b0, NO_RES},
        '{ROW_ITEM, ACT_REQUEST, 3'd0, 32'h0, 1'b0, NO_RES}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;

    swap_permutation_enumerator_top #(
        .MAX_ELEMENTS(NUM_SLOTS),
        .ELEM_WIDTH  (DATA_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // enumeration mirror
    logic [DATA_W-1:0] elem_mirror [NUM_SLOTS];
    int unsigned       lvl_swap [NUM_SLOTS];
    int unsigned       lvl_depth;
    bit                run_started;
    bit                run_done;
    logic [CNT_W-1:0]  perm_total;
    int unsigned       elem_count_reg;
    perm_result_t      pred_buf [NUM_SLOTS];

    perm_result_t      perm_q [$];
    perm_result_t      seen;
    perm_result_t      want;

    bit                quiet;
    bit                hold_flag;
    int                mismatches;
    int                idle_cycles;
    int                loads_sent;
    int                requests_sent;
    int                results_checked;
    int                exhausted_seen;
    int                count_writes;

    function automatic void swap_mirror(int unsigned a, int unsigned b);
        logic [DATA_W-1:0] t;
        if (a != b && a < NUM_SLOTS && b < NUM_SLOTS)
        begin
            t              = elem_mirror[a];
            elem_mirror[a] = elem_mirror[b];
            elem_mirror[b] = t;
        end
    endfunction

    function automatic void restart_mirror();
        int unsigned lv;
        if (run_started && !run_done)
        begin
            for (lv = lvl_depth; lv > 0; lv--)
                swap_mirror(lv - 1, lvl_swap[lv - 1]);
        end
        run_started = 1'b0;
        run_done    = 1'b0;
        perm_total  = '0;
    endfunction

    function automatic bit advance_mirror();
        int unsigned l;
        int unsigned lv;
        int unsigned j;
        l = lvl_depth;
        while (l > 0)
        begin
            lv = l - 1;
            swap_mirror(lv, lvl_swap[lv]);
            lvl_swap[lv]++;
            if (lvl_swap[lv] < lvl_depth)
            begin
                swap_mirror(lv, lvl_swap[lv]);
                for (j = lv + 1; j < lvl_depth; j++)
                    lvl_swap[j] = j;
                return 1'b1;
            end
            l--;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned used_count();
        if (elem_count_reg < 1)
            return 1;
        if (elem_count_reg > NUM_SLOTS)
            return NUM_SLOTS;
        return elem_count_reg;
    endfunction

    function automatic int predict_results(logic act, logic [POS_W-1:0] pos,
                                           logic [DATA_W-1:0] val);
        int unsigned n;
        int unsigned k;
        if (act == ACT_LOAD)
        begin
            restart_mirror();
            elem_mirror[pos] = val;
            return 0;
        end
        if (!run_done)
        begin
            if (!run_started)
            begin
                n = used_count();
                lvl_depth = n;
                for (k = 0; k < n; k++)
                    lvl_swap[k] = k;
                run_started = 1'b1;
            end
            else if (!advance_mirror())
                run_done = 1'b1;
        end
        if (run_done)
        begin
            pred_buf[0] = '{STAT_EXHAUSTED, '0, '0, 1'b1, perm_total};
            return 1;
        end
        if (perm_total != '1)
            perm_total++;
        for (k = 0; k < lvl_depth; k++)
            pred_buf[k] = '{STAT_ELEMENT, POS_W'(k), elem_mirror[k],
                            (k + 1 == lvl_depth), perm_total};
        return lvl_depth;
    endfunction

    always #1 clk = ~clk;

    task automatic send_item(logic act, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val,
                             logic typed, perm_result_t typed_res);
        int cnt;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, val, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cnt = predict_results(act, pos, val);
        if (typed)
            perm_q.push_back(typed_res);
        else
            for (int k = 0; k < cnt; k++)
                perm_q.push_back(pred_buf[k]);
        if (act == ACT_LOAD)
            loads_sent++;
        else
            requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain_requests();
        s_axis_tvalid <= 1'b0;
        while (perm_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] cnt);
        drain_requests();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        restart_mirror();
        elem_count_reg = cnt;
        count_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver side
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_flag)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_flag = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.status = m_axis_tuser;
            seen.pos    = m_axis_tdata[POS_W-1:0];
            seen.val    = m_axis_tdata[POS_W +: DATA_W];
            seen.last   = m_axis_tlast;
            seen.cnt    = m_axis_tdata[POS_W + DATA_W +: CNT_W];
            if (perm_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d pos %0d val %h last %0d cnt %0d",
                             seen.status, seen.pos, seen.val, seen.last, seen.cnt);
            end
            else
            begin
                want = perm_q.pop_front();
                results_checked++;
                if (seen.status == STAT_EXHAUSTED)
                    exhausted_seen++;
                if (seen.status !== want.status || seen.pos !== want.pos ||
                    seen.val !== want.val || seen.last !== want.last ||
                    seen.cnt !== want.cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected status %0d pos %0d val %h last %0d ",
                                  "cnt %0d, got status %0d pos %0d val %h last %0d cnt %0d"},
                                 want.status, want.pos, want.val, want.last, want.cnt,
                                 seen.status, seen.pos, seen.val, seen.last, seen.cnt);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int                forced_counts [7];
        logic [CFG_W-1:0]  cnt;
        int unsigned       n;
        int unsigned       perms;
        int                phase_items;
        int                phase;
        int                rand_items;
        logic              act;
        logic [DATA_W-1:0] val;

        forced_counts = '{1, 8, 0, 15, 4, 3, 2};
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_LOAD;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        quiet          = 1'b0;
        hold_flag      = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        loads_sent     = 0;
        requests_sent  = 0;
        results_checked = 0;
        exhausted_seen = 0;
        count_writes   = 0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            elem_mirror[k] = '0;
            lvl_swap[k]    = 0;
        end
        lvl_depth      = 0;
        run_started    = 1'b0;
        run_done       = 1'b0;
        perm_total     = '0;
        elem_count_reg = 1;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (DIRECTED_ROWS[r].kind == ROW_CFG)
                write_count(CFG_W'(DIRECTED_ROWS[r].val));
            else
                send_item(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].val,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
        end

        rand_items = 0;
        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (phase < 7)
                cnt = CFG_W'(forced_counts[phase]);
            else if ($urandom_range(0, 3) == 0)
                cnt = CFG_W'($urandom_range(0, 15));
            else
                cnt = CFG_W'($urandom_range(1, 5));
            write_count(cnt);
            n = used_count();
            if (n <= 4)
            begin
                perms = 1;
                for (int k = 2; k <= n; k++)
                    perms = perms * k;
                phase_items = perms + $urandom_range(1, 3);
            end
            else
                phase_items = $urandom_range(8, 16);
            if (phase == 1)
                hold_flag = 1'b1;
            for (int i = 0; i < phase_items && rand_items < RANDOM_ITEMS; i++)
            begin
                if (phase == 4 && i == phase_items / 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (perm_q.size() != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
                quiet = (rand_items >= QUIET_FROM);
                act = ($urandom_range(0, 9) == 0) ? ACT_LOAD : ACT_REQUEST;
                case ($urandom_range(0, 7))
                    0:       val = '0;
                    1:       val = '1;
                    default: val = $urandom;
                endcase
                send_item(act, POS_W'($urandom_range(0, NUM_SLOTS - 1)), val, 1'b0, NO_RES);
                rand_items++;
            end
            phase++;
        end

        drain_requests();
        if (perm_q.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", perm_q.size());
        end
        $display("Covered %0d loads and %0d next requests over %0d element count settings,",
                 loads_sent, requests_sent, count_writes);
        $display("with %0d results compared, %0d of them exhausted markers.",
                 results_checked, exhausted_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
